@@ sv/rcw_pkg.sv @@
// Shared types and constants of the raycast wall column shader.
// No dependencies; used by the top level and rcw_post.
package rcw_pkg;

  localparam int unsigned DIST_FRAC_BITS = 8;
  localparam int unsigned DIV_STAGES     = 4;

  localparam logic [11:0] SCREEN_HEIGHT_RST = 12'd480;
  localparam logic [15:0] VIEW_DISTANCE_RST = 16'd3584;

  // 0.2 and 0.8 in Q0.16
  localparam logic [15:0] BRIGHT_MIN  = 16'd13107;
  localparam logic [15:0] BRIGHT_SPAN = 16'd52429;

  typedef enum logic [0:0] {
    REG_SCREEN_HEIGHT = 1'b0,
    REG_VIEW_DISTANCE = 1'b1
  } cfg_reg_e;

  // Per-beat sideband that travels alongside the dividers
  typedef struct packed {
    logic        draw;
    logic        textured;
    logic [11:0] column;
    logic [23:0] base_color;
    logic [20:0] tex_u;
    logic [11:0] tex_v_top;
    logic [12:0] tex_v_bottom;
  } rcw_side_t;

endpackage

@@ sv/raycast_wall_column_shader.sv @@
// Top level of the raycast wall column shader: config registers, input stage,
// dividers and sideband line. Depends on rcw_pkg, rcw_div_pipe and rcw_post.
//
//  channel | ports                                  | handshake
//  --------+----------------------------------------+--------------------------
//  ray in  | column_i .. tex_height_i               | start_i && !busy_o
//  slice   | draw_o .. shade_color_o                | done_o, one cycle, no hold
//  config  | cfg_we_i, cfg_idx_i, cfg_data_i        | cfg_we_i
//
// One ray is taken every cycle; its slice is on the outputs while done_o is high.
// The depth is set by the input register, the two pipelined restoring dividers
// and the three back-end stages.
// busy_o stays low: nothing in the pipeline ever stalls.
// Reset clears the valid bits and loads the register defaults.
module raycast_wall_column_shader #(
  parameter int unsigned DistFracBits = rcw_pkg::DIST_FRAC_BITS,
  parameter int unsigned DivStages    = rcw_pkg::DIV_STAGES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  output logic        done_o,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic [11:0] column_i,
  input  logic        wall_hit_i,
  input  logic [15:0] distance_i,
  input  logic        side_i,
  input  logic [15:0] hit_x_i,
  input  logic [15:0] hit_y_i,
  input  logic        textured_i,
  input  logic [23:0] base_color_i,
  input  logic [11:0] tex_left_i,
  input  logic [11:0] tex_top_i,
  input  logic [11:0] tex_width_i,
  input  logic [11:0] tex_height_i,
  output logic        draw_o,
  output logic [11:0] out_column_o,
  output logic signed [15:0] y_top_o,
  output logic [15:0] y_bottom_o,
  output logic [20:0] tex_u_o,
  output logic [11:0] tex_v_top_o,
  output logic [12:0] tex_v_bottom_o,
  output logic [23:0] shade_color_o
);
  import rcw_pkg::*;

  localparam int unsigned HW = 12 + DistFracBits;
  localparam logic [16:0] One = 17'(1) << DistFracBits;

  // config registers
  logic [11:0] sh_q;
  logic [15:0] vd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q <= SCREEN_HEIGHT_RST;
      vd_q <= VIEW_DISTANCE_RST;
    end else if (cfg_we_i) begin
      priority if (cfg_idx_i == REG_SCREEN_HEIGHT) begin
        sh_q <= cfg_data_i[11:0];
      end else if (cfg_idx_i == REG_VIEW_DISTANCE) begin
        vd_q <= cfg_data_i;
      end
    end
  end

  // input stage
  logic        in_v_q;
  logic [11:0] col_q, tl_q, tt_q, tw_q, th_q;
  logic        hit_q, side_q, tex_q;
  logic [15:0] d_q, hx_q, hy_q;
  logic [23:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else begin
      in_v_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    col_q  <= column_i;
    hit_q  <= wall_hit_i;
    d_q    <= distance_i;
    side_q <= side_i;
    hx_q   <= hit_x_i;
    hy_q   <= hit_y_i;
    tex_q  <= textured_i;
    base_q <= base_color_i;
    tl_q   <= tex_left_i;
    tt_q   <= tex_top_i;
    tw_q   <= tex_width_i;
    th_q   <= tex_height_i;
  end

  // culling, texture u and the sideband beat
  logic                    draw;
  logic [15:0]             hit;
  logic [DistFracBits+11:0] prod;
  logic [20:0]             pu, u;
  logic [16:0]             vdm;
  rcw_side_t               side_d;

  assign draw = hit_q && (d_q != 16'd0) && (d_q < vd_q);
  assign hit  = side_q ? hx_q : hy_q;
  assign prod = (DistFracBits + 12)'(hit[DistFracBits-1:0]) * (DistFracBits + 12)'(tw_q);

  if (DistFracBits >= 8) begin : g_shr
    assign pu = 21'(prod >> (DistFracBits - 8));
  end else begin : g_shl
    assign pu = 21'(prod) << (8 - DistFracBits);
  end

  assign u   = 21'({tl_q, 8'h00}) + pu;
  assign vdm = (17'(vd_q) > One) ? 17'(vd_q) : One;

  always_comb begin
    side_d            = '0;
    side_d.draw       = draw;
    side_d.textured   = tex_q;
    side_d.column     = col_q;
    side_d.base_color = base_q;
    if (draw && tex_q) begin
      side_d.tex_u        = u;
      side_d.tex_v_top    = tt_q;
      side_d.tex_v_bottom = 13'(tt_q) + 13'(th_q);
    end
  end

  // dividers: wall height and normalised distance
  logic [HW-1:0] hq;
  logic [15:0]   nq;

  rcw_div_pipe #(.NB(HW), .DW(16), .STAGES(DivStages)) u_div_h (
    .clk_i (clk_i),
    .rem_i (16'd0),
    .num_i (HW'(sh_q) << DistFracBits),
    .den_i (d_q),
    .quo_o (hq)
  );

  // d < vdm on every drawn beat, so the quotient fits 16 bits
  rcw_div_pipe #(.NB(16), .DW(17), .STAGES(DivStages)) u_div_n (
    .clk_i (clk_i),
    .rem_i ({1'b0, d_q}),
    .num_i (16'd0),
    .den_i (vdm),
    .quo_o (nq)
  );

  // sideband line, aligned with the divider stages
  logic      sv_q [DivStages];
  rcw_side_t sd_q [DivStages];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivStages; i++) sv_q[i] <= 1'b0;
    end else begin
      sv_q[0] <= in_v_q;
      for (int i = 1; i < DivStages; i++) sv_q[i] <= sv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sd_q[0] <= side_d;
    for (int i = 1; i < DivStages; i++) sd_q[i] <= sd_q[i-1];
  end

  rcw_post #(.HW(HW)) u_post (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (sv_q[DivStages-1]),
    .side_i          (sd_q[DivStages-1]),
    .hq_i            (hq),
    .nq_i            (nq),
    .screen_height_i (sh_q),
    .valid_o         (done_o),
    .draw_o          (draw_o),
    .out_column_o    (out_column_o),
    .y_top_o         (y_top_o),
    .y_bottom_o      (y_bottom_o),
    .tex_u_o         (tex_u_o),
    .tex_v_top_o     (tex_v_top_o),
    .tex_v_bottom_o  (tex_v_bottom_o),
    .shade_color_o   (shade_color_o)
  );

  assign busy_o = 1'b0;

  // culled beats carry nothing but the column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !draw_o |-> y_top_o == 16'sd0 && y_bottom_o == 16'd0 &&
                          tex_u_o == 21'd0 && shade_color_o == 24'd0)
    else $error("culled slice carries payload");

  // a drawn slice never ends above its top row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && draw_o |-> $signed({1'b0, y_bottom_o}) >= $signed({y_top_o[15], y_top_o}))
    else $error("slice bottom above top");

  // a culled slice has no texture span
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && tex_v_bottom_o != 13'd0 |-> draw_o)
    else $error("texture span on culled slice");

endmodule

@@ sv/rcw_div_pipe.sv @@
// Pipelined restoring divider, a few quotient bits per register stage.
// Depends on nothing but its parameters; requires rem_i < den_i.
module rcw_div_pipe #(
  parameter int unsigned NB     = 20,
  parameter int unsigned DW     = 16,
  parameter int unsigned STAGES = 4
) (
  input  logic          clk_i,
  input  logic [DW-1:0] rem_i,
  input  logic [NB-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [NB-1:0] quo_o
);

  localparam int unsigned Sps = (NB + STAGES - 1) / STAGES;

  logic [DW-1:0] rem_q [STAGES];
  logic [NB-1:0] num_q [STAGES];
  logic [NB-1:0] quo_q [STAGES];
  logic [DW-1:0] den_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [DW-1:0] rem_in, rem_d;
    logic [NB-1:0] num_in, quo_in, quo_d;
    logic [DW-1:0] den_in;

    if (s == 0) begin : g_first
      assign rem_in = rem_i;
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign num_in = num_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    always_comb begin
      logic [DW:0] t;
      rem_d = rem_in;
      quo_d = quo_in;
      for (int k = 0; k < Sps; k++) begin
        if (s * Sps + k < NB) begin
          t = {rem_d, num_in[NB - 1 - (s * Sps + k)]};
          if (t >= {1'b0, den_in}) begin
            t = t - {1'b0, den_in};
            quo_d = {quo_d[NB-2:0], 1'b1};
          end else begin
            quo_d = {quo_d[NB-2:0], 1'b0};
          end
          rem_d = t[DW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      num_q[s] <= num_in;
      quo_q[s] <= quo_d;
      den_q[s] <= den_in;
    end
  end

  assign quo_o = quo_q[STAGES-1];

endmodule

@@ sv/rcw_post.sv @@
// Back end: wall rows, fog brightness and colour scaling in three stages.
// Depends on rcw_pkg; fed by the two dividers of the top level.
module rcw_post #(
  parameter int unsigned HW = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  rcw_pkg::rcw_side_t side_i,
  input  logic [HW-1:0]     hq_i,
  input  logic [15:0]       nq_i,
  input  logic [11:0]       screen_height_i,
  output logic              valid_o,
  output logic              draw_o,
  output logic [11:0]       out_column_o,
  output logic signed [15:0] y_top_o,
  output logic [15:0]       y_bottom_o,
  output logic [20:0]       tex_u_o,
  output logic [11:0]       tex_v_top_o,
  output logic [12:0]       tex_v_bottom_o,
  output logic [23:0]       shade_color_o
);
  import rcw_pkg::*;

  // stage 1: saturate height, square the fog term
  logic        v1_q, v2_q, v3_q;
  rcw_side_t   s1_q, s2_q;
  logic [15:0] h1_d, h1_q;
  logic [16:0] fog;
  logic [33:0] fog_sq;
  logic [16:0] f2_q;

  assign h1_d   = (hq_i > HW'(16'hFFFF)) ? 16'hFFFF : hq_i[15:0];
  assign fog    = 17'h10000 - {1'b0, nq_i};
  assign fog_sq = 34'(fog) * 34'(fog);

  // stage 2: brightness and rows
  logic [32:0]        span_p;
  logic [16:0]        b_sum;
  logic [15:0]        b_d, b_q;
  logic signed [16:0] diff, diff_adj;
  logic [16:0]        bot_sum;
  logic signed [15:0] top_q;
  logic [15:0]        bot_q;

  assign span_p   = 33'(BRIGHT_SPAN) * 33'(f2_q);
  assign b_sum    = 17'(BRIGHT_MIN) + 17'(span_p[32:16]);
  assign b_d      = b_sum[16] ? 16'hFFFF : b_sum[15:0];
  assign diff     = $signed({5'b0, screen_height_i}) - $signed({1'b0, h1_q});
  assign diff_adj = diff + 17'(diff[16]);
  assign bot_sum  = 17'(screen_height_i) + 17'(h1_q);

  // stage 3: scale colour channels (grey for textured slices, zero when culled)
  logic [23:0] r_p, g_p, bl_p, grey_p;
  logic [23:0] shade_d;

  assign r_p    = 24'(s2_q.base_color[23:16]) * 24'(b_q);
  assign g_p    = 24'(s2_q.base_color[15:8])  * 24'(b_q);
  assign bl_p   = 24'(s2_q.base_color[7:0])   * 24'(b_q);
  assign grey_p = 24'(8'hFF) * 24'(b_q);

  always_comb begin
    if (!s2_q.draw) begin
      shade_d = '0;
    end else if (s2_q.textured) begin
      shade_d = {grey_p[23:16], grey_p[23:16], grey_p[23:16]};
    end else begin
      shade_d = {r_p[23:16], g_p[23:16], bl_p[23:16]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= side_i;
    h1_q <= h1_d;
    f2_q <= fog_sq[32:16];

    s2_q  <= s1_q;
    b_q   <= b_d;
    top_q <= s1_q.draw ? 16'(diff_adj >>> 1) : '0;
    bot_q <= s1_q.draw ? bot_sum[16:1] : '0;

    draw_o         <= s2_q.draw;
    out_column_o   <= s2_q.column;
    y_top_o        <= top_q;
    y_bottom_o     <= bot_q;
    tex_u_o        <= s2_q.tex_u;
    tex_v_top_o    <= s2_q.tex_v_top;
    tex_v_bottom_o <= s2_q.tex_v_bottom;
    shade_color_o  <= shade_d;
  end

  assign valid_o = v3_q;

endmodule
